/* sv/xtea3_counter_xor_block_cipher_core_macros.svh */
// ----------------------------------------------------------------------------
// xtea3 counter core assertion macros
// shared concurrent assertion forms, clocked on clk, masked during reset
// ----------------------------------------------------------------------------
`ifndef XTEA3_COUNTER_XOR_BLOCK_CIPHER_CORE_MACROS_SVH
`define XTEA3_COUNTER_XOR_BLOCK_CIPHER_CORE_MACROS_SVH

// same-cycle implication
`define XT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xtea3 core assertion failed");

// next-cycle implication
`define XT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xtea3 core assertion failed");

`endif

/* sv/xtea3c_pkg.sv */
// ----------------------------------------------------------------------------
// xtea3c_pkg
// types, constants and round functions of the xtea3 counter core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xtea3c_pkg;

	localparam logic [31:0] XT_DELTA = 32'h9E3779B9;
	localparam int unsigned NUM_KEYS = 8;

	typedef logic [NUM_KEYS-1:0][31:0] xt_key_t;

	// one block word in flight between cells
	typedef struct packed {
		logic            decrypt;
		logic            last;
		logic [31:0]     ctr;
		logic [31:0]     ctr_after;
		logic [3:0][31:0] w;
	} xt_blk_t;

	function automatic logic [31:0] xt_rotl(input logic [31:0] x, input logic [4:0] r);
		logic [63:0] tmp;
		tmp = {x, x} << r;
		return tmp[63:32];
	endfunction

	function automatic logic [31:0] xt_mix(input logic [31:0] x, input logic [1:0] sel,
		input logic [31:0] y, input xt_key_t key);
		logic [31:0] p;
		logic [31:0] q;
		p = (x << 4) + xt_rotl(key[{1'b1, sel}], x[4:0]);
		q = (x >> 5) + xt_rotl(key[{1'b0, sel}], x[31:27]);
		return p ^ y ^ q;
	endfunction

endpackage

/* sv/xtea3c_head.sv */
// ----------------------------------------------------------------------------
// xtea3c_head
// input stage: block counter, counter mixing on encrypt and pre-whitening
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xtea3c_head (
	input  logic              clk,
	input  logic              arst_n,
	input  xtea3c_pkg::xt_key_t key,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [159:0]      s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              s_tlast,
	output logic              vld_o,
	input  logic              rdy_i,
	output xtea3c_pkg::xt_blk_t blk_o
);
	import xtea3c_pkg::*;

	logic [31:0] block_counter_q;
	logic        vld_q;
	xt_blk_t     blk_q;
	xt_blk_t     blk_d;
	logic [31:0] ctr;
	logic [3:0][31:0] win;
	logic        accept;

	assign s_tready = !vld_q || rdy_i;
	assign accept   = s_tvalid && s_tready;
	assign win      = s_tdata[159:32];
	assign ctr      = s_tuser[1] ? s_tdata[31:0] : block_counter_q;

	always_comb begin
		blk_d           = '0;
		blk_d.decrypt   = s_tuser[0];
		blk_d.last      = s_tlast;
		blk_d.ctr       = ctr;
		blk_d.ctr_after = ctr + 32'd1;
		if (s_tuser[0]) begin
			for (int i = 0; i < 4; i++)
				blk_d.w[i] = win[i] ^ key[i+4];
		end else begin
			blk_d.w[0] = (win[0] ^ ctr) + key[0];
			for (int i = 1; i < 4; i++)
				blk_d.w[i] = win[i] + key[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q           <= 1'b0;
			block_counter_q <= '0;
		end else begin
			if (s_tready)
				vld_q <= s_tvalid;
			if (accept)
				block_counter_q <= ctr + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			blk_q <= blk_d;
	end

	assign vld_o = vld_q;
	assign blk_o = blk_q;

endmodule

/* sv/xtea3c_round.sv */
// ----------------------------------------------------------------------------
// xtea3c_round
// one round cell of the chain, encrypt or decrypt per word, fixed round sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xtea3c_round #(
	parameter int unsigned IDX    = 0,
	parameter int unsigned ROUNDS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  xtea3c_pkg::xt_key_t key,
	input  logic                vld_i,
	output logic                rdy_o,
	input  xtea3c_pkg::xt_blk_t blk_i,
	output logic                vld_o,
	input  logic                rdy_i,
	output xtea3c_pkg::xt_blk_t blk_o
);
	import xtea3c_pkg::*;

	// sums before and after this round, both directions, modulo 2^32
	localparam logic [63:0] ENC_S0_W = 64'(IDX) * 64'(XT_DELTA);
	localparam logic [63:0] ENC_S1_W = 64'(IDX + 1) * 64'(XT_DELTA);
	localparam logic [63:0] DEC_S0_W = 64'(ROUNDS - IDX) * 64'(XT_DELTA);
	localparam logic [63:0] DEC_S1_W = 64'(ROUNDS - IDX - 1) * 64'(XT_DELTA);
	localparam logic [31:0] ENC_S0 = ENC_S0_W[31:0];
	localparam logic [31:0] ENC_S1 = ENC_S1_W[31:0];
	localparam logic [31:0] DEC_S0 = DEC_S0_W[31:0];
	localparam logic [31:0] DEC_S1 = DEC_S1_W[31:0];

	logic        vld_q;
	xt_blk_t     blk_q;
	xt_blk_t     blk_d;
	logic [31:0] a, b, c, d;
	logic [31:0] m1, m2;
	logic        dec;

	assign rdy_o = !vld_q || rdy_i;
	assign dec   = blk_i.decrypt;
	assign a     = blk_i.w[0];
	assign b     = blk_i.w[1];
	assign c     = blk_i.w[2];
	assign d     = blk_i.w[3];

	// the two mixes of a round are independent, both directions share the units
	assign m1 = dec ? xt_mix(a, DEC_S1[1:0], c + DEC_S1, key)
	                : xt_mix(b, ENC_S0[1:0], d + ENC_S0, key);
	assign m2 = dec ? xt_mix(c, DEC_S0[12:11], a + DEC_S0, key)
	                : xt_mix(d, ENC_S1[12:11], b + ENC_S1, key);

	always_comb begin
		blk_d = blk_i;
		if (dec) begin
			blk_d.w[0] = d - m1;
			blk_d.w[1] = a;
			blk_d.w[2] = b - m2;
			blk_d.w[3] = c;
		end else begin
			blk_d.w[0] = b;
			blk_d.w[1] = c + m2;
			blk_d.w[2] = d;
			blk_d.w[3] = a + m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rdy_o) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && vld_i)
			blk_q <= blk_d;
	end

	assign vld_o = vld_q;
	assign blk_o = blk_q;

endmodule

/* sv/xtea3c_tail.sv */
// ----------------------------------------------------------------------------
// xtea3c_tail
// output stage: post-whitening, counter mixing on decrypt, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xtea3c_tail (
	input  logic                clk,
	input  logic                arst_n,
	input  xtea3c_pkg::xt_key_t key,
	input  logic                vld_i,
	output logic                rdy_o,
	input  xtea3c_pkg::xt_blk_t blk_i,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [159:0]        m_tdata,
	output logic                m_tlast
);
	import xtea3c_pkg::*;

	logic             vld_q;
	logic [3:0][31:0] w_d;
	logic [159:0]     data_q;
	logic             last_q;

	assign rdy_o = !vld_q || m_tready;

	always_comb begin
		if (blk_i.decrypt) begin
			w_d[0] = (blk_i.w[0] - key[0]) ^ blk_i.ctr;
			for (int i = 1; i < 4; i++)
				w_d[i] = blk_i.w[i] - key[i];
		end else begin
			for (int i = 0; i < 4; i++)
				w_d[i] = blk_i.w[i] ^ key[i+4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rdy_o) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && vld_i) begin
			data_q <= {blk_i.ctr_after, w_d};
			last_q <= blk_i.last;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

/* sv/xtea3_counter_xor_block_cipher_core.sv */
// ----------------------------------------------------------------------------
// xtea3_counter_xor_block_cipher_core
// xtea3 128-bit block, 256-bit key, counter xor into word 0, round-cell chain
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata: iv, words 0..3; tuser: cmd, start
//  m_*      out  tvalid/tready      tdata: words 0..3, counter after; tlast
//  cfg_*    in   cfg_we             cfg_index selects key word, cfg_data
//
//  one word per cycle sustained while the output is not stalled; stages in order:
//  head stage, one cell per round, output register
//  every stage holds its word under stall; a stage takes a new word when it
//  is empty or its successor takes, so bubbles close up behind a stalled output
//  reset clears valid flags, block counter and key words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xtea3_counter_xor_block_cipher_core #(
	parameter int unsigned ROUNDS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,   // iv_value, in_word_0, in_word_1, in_word_2, in_word_3
	input  logic [1:0]   s_tuser,   // cmd, start_req
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,   // out_word_0..out_word_3, counter_after
	output logic         m_tlast
);
	import xtea3c_pkg::*;

	xt_key_t key_q;
	logic    vld  [ROUNDS+1];
	logic    rdy  [ROUNDS+1];
	xt_blk_t blk  [ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	xtea3c_head u_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.vld_o    (vld[0]),
		.rdy_i    (rdy[0]),
		.blk_o    (blk[0])
	);

	for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
		xtea3c_round #(
			.IDX    (g),
			.ROUNDS (ROUNDS)
		) u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.key    (key_q),
			.vld_i  (vld[g]),
			.rdy_o  (rdy[g]),
			.blk_i  (blk[g]),
			.vld_o  (vld[g+1]),
			.rdy_i  (rdy[g+1]),
			.blk_o  (blk[g+1])
		);
	end

	xtea3c_tail u_tail (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key_q),
		.vld_i    (vld[ROUNDS]),
		.rdy_o    (rdy[ROUNDS]),
		.blk_i    (blk[ROUNDS]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* sv/xtea3c_checker.sv */
// ----------------------------------------------------------------------------
// xtea3c_checker
// port-level checks of the xtea3 counter core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xtea3_counter_xor_block_cipher_core_macros.svh"

module xtea3c_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [159:0] s_tdata,
	input logic [1:0]   s_tuser,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [159:0] m_tdata,
	input logic         m_tlast
);

	// a stalled input word holds
	`XT_ASSERT_NXT(a_in_hold, s_tvalid && !s_tready, $stable({s_tvalid, s_tlast, s_tuser, s_tdata}))

	// a stalled result holds
	`XT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// a free output frees the whole chain back to the input
	`XT_ASSERT_IMP(a_ready_chain, m_tready, s_tready)

	// the input only blocks when a result waits at the output
	`XT_ASSERT_IMP(a_block_full, !s_tready, m_tvalid && !m_tready)

endmodule

bind xtea3_counter_xor_block_cipher_core xtea3c_checker u_chk (.*);
